/* hdl/fmc_pkg.sv */
// Shared types, constants and helpers of the fan mode controller.
package fmc_pkg;

    // Default parameter values
    localparam int SENSOR_WIDTH_DEF   = 16;
    localparam int PWM_FULL_SCALE_DEF = 1024;

    // Field widths that do not follow from parameters
    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int POWER_W  = 3;
    localparam int ROTATE_W = 2;
    localparam int COIL_W   = 4;
    localparam int UNITS_W  = 5;
    localparam int SPU_W    = 10;
    localparam int STEPS_W  = 12;
    localparam int DUTY_W   = 10;
    localparam int ELAPSED_W = SPU_W + UNITS_W;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = STEPS_W;

    // Command codes carried on tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_CONTROL  = 3'd0,
        CMD_DISTANCE = 3'd1,
        CMD_CLIMATE  = 3'd2,
        CMD_SECOND   = 3'd3,
        CMD_STEPPER  = 3'd4
    } t_cmd;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SECONDS_PER_UNIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEPS      = 1'b1;

    localparam logic [SPU_W-1:0]   SPU_RESET   = 10'd10;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 12'd1430;

    // Message characters
    localparam logic [CHAR_W-1:0] CHAR_P    = 8'h50;
    localparam logic [CHAR_W-1:0] CHAR_R    = 8'h52;
    localparam logic [CHAR_W-1:0] CHAR_T    = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_1    = 8'h31;
    localparam logic [CHAR_W-1:0] CHAR_3    = 8'h33;
    localparam logic [CHAR_W-1:0] CHAR_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_AUTO = 8'h41;

    localparam logic [UNITS_W-1:0] AUTO_UNITS = 5'd17;

    // Power and rotation codes
    localparam logic [POWER_W-1:0]  POWER_OFF  = 3'd0;
    localparam logic [POWER_W-1:0]  POWER_AUTO = 3'd4;
    localparam logic [ROTATE_W-1:0] ROT_OFF    = 2'd0;
    localparam logic [ROTATE_W-1:0] ROT_SWEEP  = 2'd1;
    localparam logic [ROTATE_W-1:0] ROT_EXT    = 2'd2;

    // Duty values
    localparam logic [DUTY_W-1:0] DUTY_OFF = 10'd0;
    localparam logic [DUTY_W-1:0] DUTY_L1  = 10'd200;
    localparam logic [DUTY_W-1:0] DUTY_L2  = 10'd300;
    localparam logic [DUTY_W-1:0] DUTY_L3  = 10'd400;
    localparam logic [5:0]        DUTY_PER_STEP = 6'd50;

    // Sensor thresholds, Q12.4
    localparam int SENSOR_FLOOR = -16;
    localparam int TEMP_LOW = 240;
    localparam int TEMP_BIN = 80;
    localparam int HUM_LOW  = 320;
    localparam int HUM_BIN  = 160;
    localparam int DIST_LOW = 160;
    localparam int DIST_BIN = 320;
    localparam logic [STEP_W-1:0] STEP_MAX = 4'd12;

    // Result flags and states
    typedef struct packed {
        logic                accepted;
        logic [POWER_W-1:0]  power;
        logic [ROTATE_W-1:0] rotate;
        logic [COIL_W-1:0]   coil;
        logic                running;
        logic [UNITS_W-1:0]  units;
    } t_status;

    function automatic logic [STEP_W-1:0] bin4(input int v, input int t0, input int w);
        logic [STEP_W-1:0] b;
        if (v < t0)              b = 4'd0;
        else if (v < t0 + w)     b = 4'd1;
        else if (v < t0 + 2 * w) b = 4'd2;
        else if (v < t0 + 3 * w) b = 4'd3;
        else if (v < t0 + 4 * w) b = 4'd4;
        else                     b = STEP_MAX;
        return b;
    endfunction

    // Half-step coil patterns
    function automatic logic [COIL_W-1:0] coil_fwd(input logic [2:0] idx);
        logic [COIL_W-1:0] c;
        unique case (idx)
            3'd0: c = 4'h1;
            3'd1: c = 4'h3;
            3'd2: c = 4'h2;
            3'd3: c = 4'h6;
            3'd4: c = 4'h4;
            3'd5: c = 4'hC;
            3'd6: c = 4'h8;
            3'd7: c = 4'h9;
        endcase
        return c;
    endfunction

    function automatic logic [COIL_W-1:0] coil_rev(input logic [2:0] idx);
        logic [COIL_W-1:0] c;
        unique case (idx)
            3'd0: c = 4'h8;
            3'd1: c = 4'hC;
            3'd2: c = 4'h4;
            3'd3: c = 4'h6;
            3'd4: c = 4'h2;
            3'd5: c = 4'h3;
            3'd6: c = 4'h1;
            3'd7: c = 4'h9;
        endcase
        return c;
    endfunction

endpackage

/* hdl/fmc_in_reg.sv */
// Input word register with stream handshake.
module fmc_in_reg #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_take
);

    logic         r_valid;
    logic [W-1:0] r_data;

    // Refill in the same cycle the held word moves on
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

/* hdl/fmc_core.sv */
// Fan state, configuration registers and next-state logic for one word.
module fmc_core #(
    parameter int SENSOR_WIDTH   = fmc_pkg::SENSOR_WIDTH_DEF,
    parameter int PWM_FULL_SCALE = fmc_pkg::PWM_FULL_SCALE_DEF,
    parameter int PWM_W          = $clog2(PWM_FULL_SCALE + 1),
    parameter int ITEM_W         = fmc_pkg::CMD_W + 2 * fmc_pkg::CHAR_W + 3 * SENSOR_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic [ITEM_W-1:0]                  i_item,
    input  logic                               i_cfg_we,
    input  logic [fmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fmc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output fmc_pkg::t_status                   o_status,
    output logic [PWM_W-1:0]                   o_pwm
);

    localparam int C8 = fmc_pkg::CHAR_W;
    localparam int SW = SENSOR_WIDTH;

    // Item fields
    logic [fmc_pkg::CMD_W-1:0] cmd;
    logic [C8-1:0]             mode_c;
    logic [C8-1:0]             amount_c;
    logic signed [SW-1:0]      dist_in;
    logic signed [SW-1:0]      hum_in;
    logic signed [SW-1:0]      temp_in;

    assign mode_c   = i_item[C8-1:0];
    assign amount_c = i_item[2*C8-1:C8];
    assign dist_in  = i_item[2*C8 +: SW];
    assign hum_in   = i_item[2*C8 + SW +: SW];
    assign temp_in  = i_item[2*C8 + 2*SW +: SW];
    assign cmd      = i_item[ITEM_W-1 -: fmc_pkg::CMD_W];

    // Configuration
    logic [fmc_pkg::SPU_W-1:0]   r_spu;
    logic [fmc_pkg::STEPS_W-1:0] r_steps;

    // State
    logic [fmc_pkg::POWER_W-1:0]   r_power, n_power;
    logic [fmc_pkg::ROTATE_W-1:0]  r_rotate, n_rotate;
    logic                          r_active, n_active;
    logic [fmc_pkg::UNITS_W-1:0]   r_setting, n_setting;
    logic [fmc_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [fmc_pkg::STEPS_W-1:0]   r_index, n_index;
    logic                          r_backward, n_backward;
    logic signed [SW-1:0]          r_dist, n_dist;
    logic signed [SW-1:0]          r_hum, n_hum;
    logic signed [SW-1:0]          r_temp, n_temp;
    logic [fmc_pkg::COIL_W-1:0]    r_coil, n_coil;
    logic [fmc_pkg::DUTY_W-1:0]    r_duty, n_duty;
    logic [fmc_pkg::DUTY_W-1:0]    base_duty;

    logic                          accepted;
    logic                          is_auto;
    logic                          msg_ok;
    logic [3:0]                    digit;
    logic [fmc_pkg::ELAPSED_W-1:0] limit;
    logic [fmc_pkg::ELAPSED_W-1:0] elapsed_inc;
    logic [fmc_pkg::STEPS_W-1:0]   index_inc;
    logic [fmc_pkg::STEP_W-1:0]    st, sh, sd, step_sum, step;
    logic                          sensors_ok;

    assign is_auto = (amount_c == fmc_pkg::CHAR_AUTO);
    assign digit   = amount_c[3:0];
    assign limit   = r_setting * r_spu;
    assign elapsed_inc = r_elapsed + 1'b1;
    assign index_inc   = r_index + 1'b1;

    always_comb begin
        msg_ok = 1'b0;
        priority if (mode_c == fmc_pkg::CHAR_P) begin
            msg_ok = is_auto || (amount_c >= fmc_pkg::CHAR_0 && amount_c <= fmc_pkg::CHAR_3);
        end else if (mode_c == fmc_pkg::CHAR_R) begin
            msg_ok = is_auto || (amount_c >= fmc_pkg::CHAR_0 && amount_c <= fmc_pkg::CHAR_1);
        end else if (mode_c == fmc_pkg::CHAR_T) begin
            msg_ok = is_auto || (amount_c >= fmc_pkg::CHAR_1 && amount_c <= fmc_pkg::CHAR_9);
        end else begin
            msg_ok = 1'b0;
        end
    end

    always_comb begin
        n_power    = r_power;
        n_rotate   = r_rotate;
        n_active   = r_active;
        n_setting  = r_setting;
        n_elapsed  = r_elapsed;
        n_index    = r_index;
        n_backward = r_backward;
        n_dist     = r_dist;
        n_hum      = r_hum;
        n_temp     = r_temp;
        n_coil     = r_coil;
        base_duty  = r_duty;
        accepted   = 1'b0;

        unique case (cmd)
            fmc_pkg::CMD_CONTROL: begin
                if (msg_ok) begin
                    accepted = 1'b1;
                    priority if (mode_c == fmc_pkg::CHAR_P) begin
                        if (is_auto) begin
                            n_power = fmc_pkg::POWER_AUTO;
                        end else begin
                            n_power = fmc_pkg::POWER_W'(digit);
                            unique case (digit[1:0])
                                2'd1:    base_duty = fmc_pkg::DUTY_L1;
                                2'd2:    base_duty = fmc_pkg::DUTY_L2;
                                2'd3:    base_duty = fmc_pkg::DUTY_L3;
                                default: base_duty = fmc_pkg::DUTY_OFF;
                            endcase
                            // Power off also ends a local sweep
                            if (digit == 4'd0 && r_rotate == fmc_pkg::ROT_SWEEP) begin
                                n_rotate = fmc_pkg::ROT_OFF;
                            end
                        end
                    end else if (mode_c == fmc_pkg::CHAR_R) begin
                        if (!is_auto && digit == 4'd1) begin
                            if (r_rotate != fmc_pkg::ROT_SWEEP) begin
                                n_rotate   = fmc_pkg::ROT_SWEEP;
                                n_index    = '0;
                                n_backward = 1'b0;
                            end
                        end else begin
                            n_rotate = is_auto ? fmc_pkg::ROT_EXT : fmc_pkg::ROT_OFF;
                        end
                    end else begin
                        n_setting = is_auto ? fmc_pkg::AUTO_UNITS
                                            : fmc_pkg::UNITS_W'(digit);
                        n_active  = 1'b1;
                        n_elapsed = '0;
                    end
                end
            end
            fmc_pkg::CMD_DISTANCE: begin
                n_dist = dist_in;
            end
            fmc_pkg::CMD_CLIMATE: begin
                n_hum  = hum_in;
                n_temp = temp_in;
            end
            fmc_pkg::CMD_SECOND: begin
                if (r_active) begin
                    if (elapsed_inc >= limit) begin
                        // Expire: everything off
                        n_power   = fmc_pkg::POWER_OFF;
                        n_rotate  = fmc_pkg::ROT_OFF;
                        base_duty = fmc_pkg::DUTY_OFF;
                        n_active  = 1'b0;
                        n_setting = '0;
                        n_elapsed = '0;
                    end else begin
                        n_elapsed = elapsed_inc;
                    end
                end
            end
            fmc_pkg::CMD_STEPPER: begin
                if (r_rotate == fmc_pkg::ROT_SWEEP) begin
                    n_coil = r_backward ? fmc_pkg::coil_rev(r_index[2:0])
                                        : fmc_pkg::coil_fwd(r_index[2:0]);
                    if (index_inc >= r_steps) begin
                        n_index    = '0;
                        n_backward = !r_backward;
                    end else begin
                        n_index = index_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Auto step from the sensor values after this word
    always_comb begin
        sensors_ok = !(int'(n_dist) < fmc_pkg::SENSOR_FLOOR
                    || int'(n_hum) < fmc_pkg::SENSOR_FLOOR
                    || int'(n_temp) < fmc_pkg::SENSOR_FLOOR);
        st = fmc_pkg::bin4(int'(n_temp), fmc_pkg::TEMP_LOW, fmc_pkg::TEMP_BIN);
        sh = fmc_pkg::bin4(int'(n_hum),  fmc_pkg::HUM_LOW,  fmc_pkg::HUM_BIN);
        sd = fmc_pkg::bin4(int'(n_dist), fmc_pkg::DIST_LOW, fmc_pkg::DIST_BIN);
        step_sum = st + sh + sd;
        if (st == fmc_pkg::STEP_MAX || sh == fmc_pkg::STEP_MAX || sd == fmc_pkg::STEP_MAX) begin
            step = fmc_pkg::STEP_MAX;
        end else begin
            step = step_sum;
        end
        if (int'(n_dist) < fmc_pkg::DIST_LOW || int'(n_temp) < fmc_pkg::TEMP_LOW
            || int'(n_hum) < fmc_pkg::HUM_LOW) begin
            step = '0;
        end
        // Auto duty follows the latest sensor values
        if (n_power == fmc_pkg::POWER_AUTO && sensors_ok) begin
            n_duty = fmc_pkg::DUTY_W'(step) * fmc_pkg::DUTY_PER_STEP;
        end else begin
            n_duty = base_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spu   <= fmc_pkg::SPU_RESET;
            r_steps <= fmc_pkg::STEPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fmc_pkg::REG_SECONDS_PER_UNIT: r_spu   <= i_cfg_data[fmc_pkg::SPU_W-1:0];
                fmc_pkg::REG_SWEEP_STEPS:      r_steps <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power    <= fmc_pkg::POWER_OFF;
            r_rotate   <= fmc_pkg::ROT_OFF;
            r_active   <= 1'b0;
            r_setting  <= '0;
            r_elapsed  <= '0;
            r_index    <= '0;
            r_backward <= 1'b0;
            r_dist     <= SW'(fmc_pkg::SENSOR_FLOOR);
            r_hum      <= SW'(fmc_pkg::SENSOR_FLOOR);
            r_temp     <= SW'(fmc_pkg::SENSOR_FLOOR);
            r_coil     <= '0;
            r_duty     <= fmc_pkg::DUTY_OFF;
        end else if (i_en) begin
            r_power    <= n_power;
            r_rotate   <= n_rotate;
            r_active   <= n_active;
            r_setting  <= n_setting;
            r_elapsed  <= n_elapsed;
            r_index    <= n_index;
            r_backward <= n_backward;
            r_dist     <= n_dist;
            r_hum      <= n_hum;
            r_temp     <= n_temp;
            r_coil     <= n_coil;
            r_duty     <= n_duty;
        end
    end

    always_comb begin
        o_status.accepted = accepted;
        o_status.power    = n_power;
        o_status.rotate   = n_rotate;
        o_status.coil     = n_coil;
        o_status.running  = n_active;
        o_status.units    = n_active ? n_setting : '0;
        o_pwm             = PWM_W'(PWM_FULL_SCALE - int'(n_duty));
    end

endmodule

/* hdl/fmc_out_reg.sv */
// Result word register with stream handshake.
module fmc_out_reg #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    output logic         o_can_load,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_valid;
    logic [W-1:0] r_data;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

/* hdl/fan_mode_controller.sv */
// Fan mode controller top level: input register, state update, result register.
// Path: an accepted word waits in the input register; when the result register can
//   load, the state update runs and its result is loaded there for taking.
// Throughput: one word per cycle unless a stalled result register holds the input.
// Reset (synchronous, active low): state to off, sensors to -1.0, config to
//   10 seconds per unit and 1430 sweep steps, both registers emptied.
module fan_mode_controller #(
    parameter int SENSOR_WIDTH   = fmc_pkg::SENSOR_WIDTH_DEF,
    parameter int PWM_FULL_SCALE = fmc_pkg::PWM_FULL_SCALE_DEF,
    localparam int PWM_W    = $clog2(PWM_FULL_SCALE + 1),
    localparam int IN_USED  = 2 * fmc_pkg::CHAR_W + 3 * SENSOR_WIDTH,
    localparam int IN_W     = ((IN_USED + 7) / 8) * 8,
    localparam int OUT_USED = $bits(fmc_pkg::t_status) + PWM_W,
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // mode_char, amount_char, distance_in, humidity_in, temperature_in
    input  logic [IN_W-1:0]                i_s_tdata,
    // command
    input  logic [fmc_pkg::CMD_W-1:0]      i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // accepted, pwm_level, power_state, rotate_state, coil_pattern,
    // timer_running, timer_units
    output logic [OUT_W-1:0]               o_m_tdata,
    input  logic                           i_cfg_we,
    input  logic [fmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ITEM_W = fmc_pkg::CMD_W + IN_USED;

    logic              item_valid;
    logic [ITEM_W-1:0] item;
    logic              out_can_load;
    logic              advance;
    fmc_pkg::t_status  status;
    logic [PWM_W-1:0]  pwm;
    logic [OUT_W-1:0]  result;

    assign advance = item_valid && out_can_load;

    fmc_in_reg #(.W(ITEM_W)) u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  ({i_s_tuser, i_s_tdata[IN_USED-1:0]}),
        .o_valid (item_valid),
        .o_data  (item),
        .i_take  (advance)
    );

    fmc_core #(
        .SENSOR_WIDTH   (SENSOR_WIDTH),
        .PWM_FULL_SCALE (PWM_FULL_SCALE),
        .PWM_W          (PWM_W),
        .ITEM_W         (ITEM_W)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_item      (item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_pwm       (pwm)
    );

    assign result = OUT_W'({status.units, status.running, status.coil, status.rotate,
                            status.power, pwm, status.accepted});

    fmc_out_reg #(.W(OUT_W)) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .o_can_load (out_can_load),
        .i_data     (result),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_data     (o_m_tdata)
    );

endmodule

/* hdl/fmc_checker.sv */
// Port-level checks of the fan mode controller, bound to the top level.
module fmc_checker #(
    parameter int SENSOR_WIDTH   = fmc_pkg::SENSOR_WIDTH_DEF,
    parameter int PWM_FULL_SCALE = fmc_pkg::PWM_FULL_SCALE_DEF,
    localparam int PWM_W    = $clog2(PWM_FULL_SCALE + 1),
    localparam int IN_USED  = 2 * fmc_pkg::CHAR_W + 3 * SENSOR_WIDTH,
    localparam int IN_W     = ((IN_USED + 7) / 8) * 8,
    localparam int OUT_USED = $bits(fmc_pkg::t_status) + PWM_W,
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [IN_W-1:0]                i_s_tdata,
    input logic [fmc_pkg::CMD_W-1:0]      i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [OUT_W-1:0]               o_m_tdata,
    input logic                           i_cfg_we,
    input logic [fmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [fmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int POS_POWER  = 1 + PWM_W;
    localparam int POS_ROTATE = POS_POWER + fmc_pkg::POWER_W;
    localparam int POS_RUN    = POS_ROTATE + fmc_pkg::ROTATE_W + fmc_pkg::COIL_W;
    localparam int POS_UNITS  = POS_RUN + 1;

    logic [fmc_pkg::POWER_W-1:0]  power;
    logic [fmc_pkg::ROTATE_W-1:0] rotate;
    logic                         running;
    logic [fmc_pkg::UNITS_W-1:0]  units;

    assign power   = o_m_tdata[POS_POWER +: fmc_pkg::POWER_W];
    assign rotate  = o_m_tdata[POS_ROTATE +: fmc_pkg::ROTATE_W];
    assign running = o_m_tdata[POS_RUN];
    assign units   = o_m_tdata[POS_UNITS +: fmc_pkg::UNITS_W];

    // No result word is valid right after reset
    a_no_early_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !running |-> units == '0)
        else $error("timer units shown while timer idle");

    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> power <= fmc_pkg::POWER_AUTO && rotate <= fmc_pkg::ROT_EXT)
        else $error("power or rotation code out of range");

    // Input side must not stall while both registers are drained
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid && $past(!o_m_tvalid) && $past(i_rst_n) && !$past(i_s_tvalid)
        |-> o_s_tready)
        else $error("input stalled with empty pipeline");

endmodule

bind fan_mode_controller fmc_checker #(
    .SENSOR_WIDTH   (SENSOR_WIDTH),
    .PWM_FULL_SCALE (PWM_FULL_SCALE)
) u_fmc_checker (.*);
